// File: sv/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared sizes, opcode and state encodings, and the memory request bundle.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 40;

    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int IDX_BITS   = 10;
    localparam int VAL_IN_BITS = 40;
    localparam int TOTAL_BITS = 50;

    localparam int ROOT_STEPS = (VALUE_BITS + 1) / 2;
    localparam int ROOT_BITS  = ROOT_STEPS;
    localparam int PAD_BITS   = 2 * ROOT_STEPS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int CNT_BITS   = $clog2(ROOT_STEPS + 1);

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ROOT   = 2'd1,
        FUNC_ASSIGN = 2'd2,
        FUNC_SUM    = 2'd3
    } func_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ASSIGN = 8'b0000_0010,
        S_SUM    = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_FIN    = 8'b0001_0000,
        S_RREAD  = 8'b0010_0000,
        S_RSTART = 8'b0100_0000,
        S_RRUN   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic                  re;
        logic [ADDR_BITS-1:0]  raddr;
    } mem_req_t;

endpackage

// File: sv/rsq_store.sv
// ----------------------------------------------------------------------------
// rsq_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsq_store (
    input  logic                           clk,
    input  rsq_pkg::mem_req_t              req,
    output logic [rsq_pkg::VALUE_BITS-1:0] rd_data
);

    logic [rsq_pkg::VALUE_BITS-1:0] mem [rsq_pkg::DEPTH];
    logic [rsq_pkg::VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rsq_root.sv
// ----------------------------------------------------------------------------
// rsq_root
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rsq_root (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rsq_pkg::VALUE_BITS-1:0] operand,
    output logic                           done,
    output logic [rsq_pkg::ROOT_BITS-1:0]  root
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rsq_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [rsq_pkg::PAD_BITS-1:0]  opnd_reg, opnd_next;
    logic [rsq_pkg::REM_BITS-1:0]  rem_reg, rem_next;
    logic [rsq_pkg::ROOT_BITS-1:0] root_reg, root_next;

    logic [rsq_pkg::REM_BITS-1:0]  rem_sh;
    logic [rsq_pkg::REM_BITS-1:0]  trial;

    always_comb
    begin
        rem_sh    = {rem_reg[rsq_pkg::REM_BITS-3:0], opnd_reg[rsq_pkg::PAD_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        opnd_next = opnd_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = rsq_pkg::CNT_BITS'(rsq_pkg::ROOT_STEPS);
            opnd_next = rsq_pkg::PAD_BITS'(operand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            opnd_next = opnd_reg << 2;
            cnt_next  = cnt_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[rsq_pkg::ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[rsq_pkg::ROOT_BITS-2:0], 1'b0};
            end
            if (cnt_reg == rsq_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("root start while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("root done without a finished run");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("root busy with empty step count");

endmodule

// File: sv/range_sqrt_range_sum_store_top.sv
// ----------------------------------------------------------------------------
// range_sqrt_range_sum_store_top
// Range load / floor-root / assign / sum over a 1024 x 40 element memory.
// ----------------------------------------------------------------------------
// One beat is handled at a time; in_ready is high only while the block is
// idle. A load writes its element directly from the idle state. A range
// assign makes one memory write per cycle for its elements. A range sum
// makes one memory read per cycle, plus a wait if the previous result beat
// is still held on the output register. In a range square root each
// element is read, passed through the iterative root unit at one root bit
// per cycle, and written back. Elements have no reset value and must be
// loaded before they are read; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module range_sqrt_range_sum_store_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [rsq_pkg::IDX_BITS-1:0]    first,
    input  logic [rsq_pkg::IDX_BITS-1:0]    last,
    input  logic [rsq_pkg::VAL_IN_BITS-1:0] value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rsq_pkg::TOTAL_BITS-1:0]  range_total
);

    rsq_pkg::state_t                state_reg, state_next;
    logic [rsq_pkg::IDX_BITS-1:0]   idx_reg, idx_next;
    logic [rsq_pkg::IDX_BITS-1:0]   hi_reg, hi_next;
    logic [rsq_pkg::VALUE_BITS-1:0] val_reg, val_next;
    logic [rsq_pkg::TOTAL_BITS-1:0] acc_reg, acc_next;
    logic                           sum_pend_reg, sum_pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [rsq_pkg::TOTAL_BITS-1:0] total_reg, total_next;

    rsq_pkg::mem_req_t              req;
    logic [rsq_pkg::VALUE_BITS-1:0] rd_data;
    logic                           root_start;
    logic                           root_done;
    logic [rsq_pkg::ROOT_BITS-1:0]  root_val;

    rsq_pkg::func_t                 op;
    logic                           accept;
    logic [rsq_pkg::IDX_BITS-1:0]   lo_s, hi_s, hi_c;
    logic                           empty;
    logic                           last_idx;
    logic                           out_free;

    assign op       = rsq_pkg::func_t'(func);
    assign accept   = in_valid && (state_reg == rsq_pkg::S_IDLE);
    assign last_idx = (idx_reg == hi_reg);
    assign out_free = !out_valid_reg || out_ready;

    // order the ends, then clip to the last element
    always_comb
    begin
        lo_s = (last < first) ? last : first;
        hi_s = (last < first) ? first : last;
        if (32'(hi_s) >= 32'(rsq_pkg::DEPTH))
        begin
            hi_c = rsq_pkg::IDX_BITS'(rsq_pkg::DEPTH - 1);
        end
        else
        begin
            hi_c = hi_s;
        end
        empty = (lo_s > hi_c);
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        sum_pend_next  = (state_reg == rsq_pkg::S_SUM);
        out_valid_next = out_valid_reg && !out_ready;
        total_next     = total_reg;
        root_start     = 1'b0;

        req.we    = 1'b0;
        req.waddr = rsq_pkg::ADDR_BITS'(idx_reg);
        req.wdata = val_reg;
        req.re    = (state_reg == rsq_pkg::S_SUM) || (state_reg == rsq_pkg::S_RREAD);
        req.raddr = rsq_pkg::ADDR_BITS'(idx_reg);

        if (sum_pend_reg)
        begin
            acc_next = acc_reg + rsq_pkg::TOTAL_BITS'(rd_data);
        end

        unique case (state_reg)
            rsq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = lo_s;
                    hi_next  = hi_c;
                    val_next = rsq_pkg::VALUE_BITS'(value);
                    acc_next = '0;
                    unique case (op)
                        rsq_pkg::FUNC_LOAD:
                        begin
                            req.we    = (32'(first) < 32'(rsq_pkg::DEPTH));
                            req.waddr = rsq_pkg::ADDR_BITS'(first);
                            req.wdata = rsq_pkg::VALUE_BITS'(value);
                        end
                        rsq_pkg::FUNC_ROOT:
                        begin
                            state_next = empty ? rsq_pkg::S_IDLE : rsq_pkg::S_RREAD;
                        end
                        rsq_pkg::FUNC_ASSIGN:
                        begin
                            state_next = empty ? rsq_pkg::S_IDLE : rsq_pkg::S_ASSIGN;
                        end
                        rsq_pkg::FUNC_SUM:
                        begin
                            state_next = empty ? rsq_pkg::S_FIN : rsq_pkg::S_SUM;
                        end
                        default:
                        begin
                            state_next = rsq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rsq_pkg::S_ASSIGN:
            begin
                req.we = 1'b1;
                if (last_idx)
                begin
                    state_next = rsq_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            rsq_pkg::S_SUM:
            begin
                if (last_idx)
                begin
                    state_next = rsq_pkg::S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            rsq_pkg::S_DRAIN:
            begin
                state_next = rsq_pkg::S_FIN;
            end
            rsq_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    total_next     = acc_reg;
                    state_next     = rsq_pkg::S_IDLE;
                end
            end
            rsq_pkg::S_RREAD:
            begin
                state_next = rsq_pkg::S_RSTART;
            end
            rsq_pkg::S_RSTART:
            begin
                root_start = 1'b1;
                state_next = rsq_pkg::S_RRUN;
            end
            rsq_pkg::S_RRUN:
            begin
                if (root_done)
                begin
                    req.we    = 1'b1;
                    req.wdata = rsq_pkg::VALUE_BITS'(root_val);
                    if (last_idx)
                    begin
                        state_next = rsq_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = rsq_pkg::S_RREAD;
                    end
                end
            end
            default:
            begin
                state_next = rsq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsq_pkg::S_IDLE;
            sum_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_pend_reg  <= sum_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        hi_reg    <= hi_next;
        val_reg   <= val_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
    end

    rsq_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    rsq_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (rd_data),
        .done    (root_done),
        .root    (root_val)
    );

    assign in_ready    = (state_reg == rsq_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign range_total = total_reg;

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.we && req.re && (req.waddr == req.raddr)))
        else $error("memory read and write to the same entry");

    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == rsq_pkg::S_RRUN)
        else $error("root result outside the root wait state");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsq_pkg::S_SUM || state_reg == rsq_pkg::S_ASSIGN
         || state_reg == rsq_pkg::S_RREAD) |-> idx_reg <= hi_reg)
        else $error("range walk passed the last index");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsq_pkg::S_FIN && out_valid_reg && !out_ready)
        |=> state_reg == rsq_pkg::S_FIN)
        else $error("sum result dropped while output slot busy");

endmodule
